// File: design/xcpd_pkg.sv
// Package for the XOR-checked packet deframer.
// Holds parser states, result status codes, register indexes and store sizes.
// No dependencies.
`default_nettype none

package xcpd_pkg;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned StoreAw    = 6;
  localparam int unsigned MaxPayload = 64;
  // effective cap on a payload length, whatever max_length says
  localparam int unsigned LenCap = (MaxPayload < StoreDepth) ? MaxPayload : StoreDepth;

  localparam int unsigned CfgAw = 2;
  localparam int unsigned CfgDw = 8;

  localparam logic [CfgAw-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgAw-1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [CfgAw-1:0] CFG_MAX_LENGTH   = 2'd2;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_BADLEN = 2'd1,
    ST_BADSUM = 2'd2,
    ST_NOEND  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_START   = 3'd0,
    S_TYPE    = 3'd1,
    S_LENGTH  = 3'd2,
    S_PAYLOAD = 3'd3,
    S_CHECK   = 3'd4,
    S_END     = 3'd5,
    S_RD      = 3'd6,
    S_LOAD    = 3'd7
  } phase_e;

endpackage : xcpd_pkg

`default_nettype wire

// File: design/xor_checked_packet_deframer_unit.sv
// Top level of the XOR-checked packet deframer: frame parser and payload replay.
// Depends on xcpd_pkg and xcpd_ram.
`default_nettype none

// Usage:
//   Received bytes enter on the s_axis channel, one byte per transaction.
//   A frame is start byte, type, length, payload, XOR checksum, end byte.
//   Results leave on the m_axis channel. A good frame gives one transaction
//   per payload byte (or one for an empty payload), tlast on the final one.
//   A bad length, checksum mismatch or wrong end byte gives one error result.
//   Latency: an error or empty-packet result appears the cycle after the
//   byte that caused it. Payload replay starts after the end byte; for each
//   byte the store's registered read is issued in S_RD and the byte is
//   loaded into the output register in S_LOAD. During replay s_axis
//   is not ready. Otherwise one input byte per cycle is taken.
//   Stalls: the output register holds a result until m_axis_tready; while it
//   is full and stalled, no input byte is taken and replay pauses.
//   Reset: parser hunts for the start byte, registers return to 0xAA, 0x55
//   and 64; the payload store is not cleared (only entries written by the
//   current packet are read). Configuration is written through cfg_we_i.
module xor_checked_packet_deframer_unit
  import xcpd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgAw-1:0]  cfg_addr_i,
  input  wire logic [CfgDw-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [7:0] msg_type, [14:8] msg_length, [20:15] byte_index,
  // [28:21] payload_byte, [31:29] zero
  output logic [31:0]            m_axis_tdata,
  output logic [2:0]             m_axis_tuser,   // [1:0] status, [2] data_valid
  output logic                   m_axis_tlast
);

  // configuration
  logic [7:0] start_mk_q, end_mk_q;
  logic [6:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mk_q <= 8'd170;
      end_mk_q   <= 8'd85;
      max_len_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_START_MARKER: start_mk_q <= cfg_wdata_i;
        CFG_END_MARKER:   end_mk_q   <= cfg_wdata_i;
        CFG_MAX_LENGTH:   max_len_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  phase_e      state_q, state_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [6:0]  held_len_q, held_len_d;
  logic [6:0]  fill_q, fill_d;
  logic [7:0]  xor_q, xor_d;
  logic [StoreAw-1:0] rd_idx_q, rd_idx_d;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [7:0]  out_type_q, out_type_d;
  logic [6:0]  out_len_q, out_len_d;
  logic        out_dv_q, out_dv_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;

  logic        out_free, in_acc, out_load;
  logic [7:0]  b;
  logic [6:0]  len_limit;
  logic        len_ok, fill_done, rep_last;
  logic [6:0]  fill_inc;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;

  assign b         = s_axis_tdata;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q != S_RD) && (state_q != S_LOAD) && out_free;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign len_limit = (max_len_q > 7'(LenCap)) ? 7'(LenCap) : max_len_q;
  assign len_ok    = (b <= {1'b0, len_limit});
  assign fill_inc  = fill_q + 7'd1;
  assign fill_done = (fill_inc >= held_len_q);
  assign rep_last  = ({1'b0, rd_idx_q} + 7'd1 == held_len_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_START: if (in_acc && b == start_mk_q) state_d = S_TYPE;
      S_TYPE:  if (in_acc) state_d = S_LENGTH;
      S_LENGTH: begin
        if (in_acc) begin
          if (b == 8'd0)  state_d = S_CHECK;
          else if (len_ok) state_d = S_PAYLOAD;
          else            state_d = S_START;
        end
      end
      S_PAYLOAD: if (in_acc && fill_done) state_d = S_CHECK;
      S_CHECK: begin
        if (in_acc) state_d = (b == xor_q) ? S_END : S_START;
      end
      S_END: begin
        if (in_acc) begin
          state_d = (b == end_mk_q && held_len_q != 7'd0) ? S_RD : S_START;
        end
      end
      S_RD:   state_d = S_LOAD;
      S_LOAD: if (out_free) state_d = rep_last ? S_START : S_RD;
      default: state_d = S_START;
    endcase
  end

  // datapath and result register
  always_comb begin
    held_type_d  = held_type_q;
    held_len_d   = held_len_q;
    fill_d       = fill_q;
    xor_d        = xor_q;
    rd_idx_d     = rd_idx_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_type_d   = out_type_q;
    out_len_d    = out_len_q;
    out_dv_d     = out_dv_q;
    out_idx_d    = out_idx_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    case (state_q)
      S_TYPE: begin
        if (in_acc) begin
          held_type_d = b;
          xor_d       = b;
        end
      end
      S_LENGTH: begin
        if (in_acc) begin
          fill_d     = 7'd0;
          xor_d      = xor_q ^ b;
          held_len_d = b[6:0];
          if (b != 8'd0 && !len_ok) begin
            out_load     = 1'b1;
            out_status_d = ST_BADLEN;
            out_len_d    = b[6:0];
          end
        end
      end
      S_PAYLOAD: begin
        if (in_acc) begin
          ram_we = 1'b1;
          xor_d  = xor_q ^ b;
          fill_d = fill_inc;
        end
      end
      S_CHECK: begin
        if (in_acc && b != xor_q) begin
          out_load     = 1'b1;
          out_status_d = ST_BADSUM;
          out_len_d    = held_len_q;
        end
      end
      S_END: begin
        if (in_acc) begin
          rd_idx_d = '0;
          if (b != end_mk_q) begin
            out_load     = 1'b1;
            out_status_d = ST_NOEND;
            out_len_d    = held_len_q;
          end else if (held_len_q == 7'd0) begin
            out_load     = 1'b1;
            out_status_d = ST_DATA;
            out_len_d    = 7'd0;
          end
        end
      end
      S_RD: ram_re = 1'b1;
      S_LOAD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_DATA;
          out_len_d    = held_len_q;
          rd_idx_d     = rd_idx_q + StoreAw'(1);
        end
      end
      default: ;
    endcase

    // error and empty-packet results share the same framing; replay results carry index, byte and last flag
    if (out_load) begin
      out_type_d = (state_q == S_TYPE) ? b : held_type_q;
      if (state_q == S_LOAD) begin
        out_dv_d   = 1'b1;
        out_idx_d  = rd_idx_q;
        out_byte_d = ram_rdata;
        out_last_d = rep_last;
      end else begin
        out_dv_d   = 1'b0;
        out_idx_d  = 6'd0;
        out_byte_d = 8'd0;
        out_last_d = 1'b1;
      end
    end
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START;
      held_type_q <= 8'd0;
      held_len_q  <= 7'd0;
      fill_q      <= 7'd0;
      xor_q       <= 8'd0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_type_q <= held_type_d;
      held_len_q  <= held_len_d;
      fill_q      <= fill_d;
      xor_q       <= xor_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_type_q   <= out_type_d;
    out_len_q    <= out_len_d;
    out_dv_q     <= out_dv_d;
    out_idx_q    <= out_idx_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
  end

  xcpd_ram #(
    .Width (8),
    .Depth (64)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[StoreAw-1:0]),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_byte_q, out_idx_q, out_len_q, out_type_q};
  assign m_axis_tuser  = {out_dv_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule : xor_checked_packet_deframer_unit

`default_nettype wire

// File: design/xcpd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module xcpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : xcpd_ram

`default_nettype wire
